>>> sv/sll_pkg.sv
// Package for the static linked list engine: state encoding, operation codes
// and status codes. No dependencies.
`default_nettype none

package sll_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_INS_FREE,
        S_INS_NFREE,
        S_WALK,
        S_INS_LINK,
        S_DEL_A,
        S_DEL_B,
        S_DEL_C,
        S_TRV_HEAD,
        S_TRV_ITEM,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } t_status;

    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_DELETE   = 2'd1;
    localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

endpackage

`default_nettype wire

>>> sv/static_linked_list_engine.sv
// Static linked list engine: link and data memories with the sequencer that
// walks, links and unlinks nodes. Depends on sll_pkg.
`default_nettype none

// Usage
// Input channel (i_in_valid / o_in_ready) carries one operation: insert,
// delete or traverse. Output channel (o_out_valid / i_out_ready) returns the
// results; the last result of an operation carries o_is_last.
// Node 0 heads the free chain and node 1 heads the list, so DEPTH-2 elements
// fit. One operation is in work at a time; a new one is taken once the last
// result of the previous one sits in the output register.
// Insert and delete walk the list from its head to the given position; the
// walk reads one link per cycle from the link memory. Traverse reads the
// elements in list order and returns one result per element.
// After reset the link memory is initialized by a pass over all DEPTH entries,
// one entry per cycle; no operation is taken during that pass.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before loading the next one; a single-result operation
// can still be accepted and worked up to that point.
module static_linked_list_engine #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [1:0]  i_func,
    input  wire logic        [5:0]  i_position,
    input  wire logic signed [31:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed      [31:0] o_element,
    output logic             [1:0]  o_status,
    output logic             [5:0]  o_list_length,
    output logic                    o_is_last
);

    localparam int LW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH - 1);
    localparam int DW = VALUE_BITS;
    localparam int KW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int XW = (CW + 1 > 6) ? CW + 1 : 6;

    // Memories
    logic [LW-1:0] link_mem [DEPTH];
    logic [DW-1:0] data_mem [DEPTH];
    logic [LW-1:0] r_link_q;
    logic [DW-1:0] r_data_q;

    logic          link_re;
    logic [LW-1:0] link_raddr;
    logic          link_we;
    logic [LW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic          data_re;
    logic [LW-1:0] data_raddr;
    logic          data_we;
    logic [LW-1:0] data_waddr;

    // Control and working registers
    sll_pkg::t_state  r_state, n_state;
    sll_pkg::t_status r_status, n_status;
    logic [1:0]    r_func, n_func;
    logic [5:0]    r_pos, n_pos;
    logic [DW-1:0] r_val, n_val;
    logic [LW-1:0] r_k, n_k;
    logic [5:0]    r_steps, n_steps;
    logic [LW-1:0] r_node, n_node;
    logic [LW-1:0] r_plink, n_plink;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_clr, n_clr;

    // Output register
    logic                r_out_valid;
    logic [31:0]         r_out_elem;
    sll_pkg::t_status    r_out_status;
    logic [5:0]          r_out_len;
    logic                r_out_last;

    logic                emit;
    logic [31:0]         emit_elem;
    sll_pkg::t_status    emit_status;
    logic                emit_last;

    // Shared conditions
    logic          can_emit;
    logic [XW-1:0] pos_x, cnt_x, cnt1_x;
    logic          ins_bad, del_bad;
    logic [CW:0]   n_plus1;
    logic          trv_last;
    logic [LW-1:0] clr_init;

    assign can_emit = !r_out_valid || i_out_ready;
    assign pos_x    = XW'(r_pos);
    assign cnt_x    = XW'(r_count);
    assign cnt1_x   = cnt_x + XW'(1);
    assign ins_bad  = (r_pos == 6'd0) || (pos_x > cnt1_x);
    assign del_bad  = (r_pos == 6'd0) || (pos_x > cnt_x);
    assign n_plus1  = (CW + 1)'(r_n) + (CW + 1)'(1);
    assign trv_last = (r_link_q == LW'(0)) || (n_plus1 >= (CW + 1)'(r_count))
                      || (n_plus1 >= (CW + 1)'(DEPTH - 2));

    // Reset image of the links: 0 -> 2 -> 3 -> ... -> DEPTH-1 -> 0, list empty.
    assign clr_init = (r_clr == LW'(0)) ? LW'(2) :
                      ((r_clr == LW'(1)) || (r_clr == LW'(DEPTH - 1))) ? LW'(0) :
                      r_clr + LW'(1);

    assign o_in_ready    = (r_state == sll_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_element     = r_out_elem;
    assign o_status      = r_out_status;
    assign o_list_length = r_out_len;
    assign o_is_last     = r_out_last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sll_pkg::S_CLEAR: begin
                if (r_clr == LW'(DEPTH - 1)) begin
                    n_state = sll_pkg::S_IDLE;
                end
            end
            sll_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sll_pkg::S_CHECK;
                end
            end
            sll_pkg::S_CHECK: begin
                case (r_func)
                    sll_pkg::FUNC_INSERT: begin
                        n_state = ins_bad ? sll_pkg::S_EMIT : sll_pkg::S_INS_FREE;
                    end
                    sll_pkg::FUNC_DELETE: begin
                        n_state = del_bad ? sll_pkg::S_EMIT : sll_pkg::S_WALK;
                    end
                    sll_pkg::FUNC_TRAVERSE: begin
                        n_state = (r_count == CW'(0)) ? sll_pkg::S_EMIT
                                                      : sll_pkg::S_TRV_HEAD;
                    end
                    default: begin
                        n_state = sll_pkg::S_IDLE;
                    end
                endcase
            end
            sll_pkg::S_INS_FREE: begin
                n_state = (r_link_q < LW'(2)) ? sll_pkg::S_EMIT : sll_pkg::S_INS_NFREE;
            end
            sll_pkg::S_INS_NFREE: begin
                n_state = sll_pkg::S_WALK;
            end
            sll_pkg::S_WALK: begin
                if (r_steps == 6'd0) begin
                    if (r_func == sll_pkg::FUNC_INSERT) begin
                        n_state = sll_pkg::S_INS_LINK;
                    end else begin
                        n_state = (r_link_q < LW'(2)) ? sll_pkg::S_EMIT : sll_pkg::S_DEL_A;
                    end
                end
            end
            sll_pkg::S_INS_LINK: n_state = sll_pkg::S_EMIT;
            sll_pkg::S_DEL_A:    n_state = sll_pkg::S_DEL_B;
            sll_pkg::S_DEL_B:    n_state = sll_pkg::S_DEL_C;
            sll_pkg::S_DEL_C:    n_state = sll_pkg::S_EMIT;
            sll_pkg::S_TRV_HEAD: begin
                n_state = (r_link_q == LW'(0)) ? sll_pkg::S_EMIT : sll_pkg::S_TRV_ITEM;
            end
            sll_pkg::S_TRV_ITEM: begin
                if (can_emit && trv_last) begin
                    n_state = sll_pkg::S_IDLE;
                end
            end
            sll_pkg::S_EMIT: begin
                if (can_emit) begin
                    n_state = sll_pkg::S_IDLE;
                end
            end
            default: n_state = sll_pkg::S_IDLE;
        endcase
    end

    // Memory controls, working registers and result requests
    always_comb begin
        link_re     = 1'b0;
        link_raddr  = r_link_q;
        link_we     = 1'b0;
        link_waddr  = r_node;
        link_wdata  = r_link_q;
        data_re     = 1'b0;
        data_raddr  = r_link_q;
        data_we     = 1'b0;
        data_waddr  = r_node;
        emit        = 1'b0;
        emit_elem   = 32'd0;
        emit_status = r_status;
        emit_last   = 1'b1;
        n_status    = r_status;
        n_func      = r_func;
        n_pos       = r_pos;
        n_val       = r_val;
        n_k         = r_k;
        n_steps     = r_steps;
        n_node      = r_node;
        n_plink     = r_plink;
        n_n         = r_n;
        n_count     = r_count;
        n_clr       = r_clr;
        case (r_state)
            sll_pkg::S_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_clr;
                link_wdata = clr_init;
                n_clr      = r_clr + LW'(1);
            end
            sll_pkg::S_IDLE: begin
                n_func = i_func;
                n_pos  = i_position;
                n_val  = DW'(i_value[KW-1:0]);
            end
            sll_pkg::S_CHECK: begin
                case (r_func)
                    sll_pkg::FUNC_INSERT: begin
                        n_status   = sll_pkg::STATUS_RANGE;
                        link_re    = !ins_bad;
                        link_raddr = LW'(0);
                    end
                    sll_pkg::FUNC_DELETE: begin
                        n_status   = sll_pkg::STATUS_RANGE;
                        link_re    = !del_bad;
                        link_raddr = LW'(1);
                        n_k        = LW'(1);
                        n_steps    = r_pos - 6'd1;
                    end
                    sll_pkg::FUNC_TRAVERSE: begin
                        n_status   = sll_pkg::STATUS_EMPTY;
                        link_re    = (r_count != CW'(0));
                        link_raddr = LW'(1);
                    end
                    default: begin
                        n_status = r_status;
                    end
                endcase
            end
            sll_pkg::S_INS_FREE: begin
                // The free chain head is the node that will take the value.
                n_node     = r_link_q;
                n_status   = sll_pkg::STATUS_FULL;
                link_re    = (r_link_q >= LW'(2));
                link_raddr = r_link_q;
            end
            sll_pkg::S_INS_NFREE: begin
                // Pop the free chain while the list walk starts at the head.
                link_we    = 1'b1;
                link_waddr = LW'(0);
                link_wdata = r_link_q;
                link_re    = 1'b1;
                link_raddr = LW'(1);
                n_k        = LW'(1);
                n_steps    = r_pos - 6'd1;
            end
            sll_pkg::S_WALK: begin
                if (r_steps == 6'd0) begin
                    if (r_func == sll_pkg::FUNC_INSERT) begin
                        link_we    = 1'b1;
                        link_waddr = r_k;
                        link_wdata = r_node;
                        data_we    = 1'b1;
                        data_waddr = r_node;
                        n_plink    = r_link_q;
                    end else begin
                        n_node     = r_link_q;
                        n_status   = sll_pkg::STATUS_RANGE;
                        link_re    = (r_link_q >= LW'(2));
                        link_raddr = r_link_q;
                    end
                end else begin
                    n_k        = r_link_q;
                    n_steps    = r_steps - 6'd1;
                    link_re    = 1'b1;
                    link_raddr = r_link_q;
                end
            end
            sll_pkg::S_INS_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_node;
                link_wdata = r_plink;
                n_count    = r_count + CW'(1);
                n_status   = sll_pkg::STATUS_OK;
            end
            sll_pkg::S_DEL_A: begin
                // Bypass the node in the list and fetch the free chain head.
                link_we    = 1'b1;
                link_waddr = r_k;
                link_wdata = r_link_q;
                link_re    = 1'b1;
                link_raddr = LW'(0);
            end
            sll_pkg::S_DEL_B: begin
                link_we    = 1'b1;
                link_waddr = r_node;
                link_wdata = r_link_q;
            end
            sll_pkg::S_DEL_C: begin
                link_we    = 1'b1;
                link_waddr = LW'(0);
                link_wdata = r_node;
                n_count    = r_count - CW'(1);
                n_status   = sll_pkg::STATUS_OK;
            end
            sll_pkg::S_TRV_HEAD: begin
                n_status   = sll_pkg::STATUS_EMPTY;
                n_n        = CW'(0);
                link_re    = (r_link_q != LW'(0));
                link_raddr = r_link_q;
                data_re    = (r_link_q != LW'(0));
                data_raddr = r_link_q;
            end
            sll_pkg::S_TRV_ITEM: begin
                // The read data holds while the output register is busy.
                if (can_emit) begin
                    emit        = 1'b1;
                    emit_elem   = 32'(r_data_q[KW-1:0]);
                    emit_status = sll_pkg::STATUS_OK;
                    emit_last   = trv_last;
                    if (!trv_last) begin
                        n_n        = r_n + CW'(1);
                        link_re    = 1'b1;
                        link_raddr = r_link_q;
                        data_re    = 1'b1;
                        data_raddr = r_link_q;
                    end
                end
            end
            sll_pkg::S_EMIT: begin
                emit = can_emit;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_q <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[data_waddr] <= r_val;
        end
        if (data_re) begin
            r_data_q <= data_mem[data_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sll_pkg::S_CLEAR;
            r_clr       <= LW'(0);
            r_count     <= CW'(0);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_func   <= n_func;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_k      <= n_k;
        r_steps  <= n_steps;
        r_node   <= n_node;
        r_plink  <= n_plink;
        r_n      <= n_n;
        if (emit) begin
            r_out_elem   <= emit_elem;
            r_out_status <= emit_status;
            r_out_len    <= 6'(r_count);
            r_out_last   <= emit_last;
        end
    end

`ifndef SYNTH
    // The store reports full only when every usable node is on the list.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (emit_status == sll_pkg::STATUS_FULL)) |-> (r_count == CW'(DEPTH - 2)))
        else $error("store full reported with free nodes left");

    // No cycle reads and writes the same link entry.
    a_link_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (link_we && link_re) |-> (link_waddr != link_raddr))
        else $error("link read and write collide");

    // The final result of an operation returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == sll_pkg::S_IDLE))
        else $error("sequencer busy after final result");

    // The element count moves by one at a time.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count + CW'(1) == $past(r_count))))
        else $error("element count jumped");
`endif

endmodule

`default_nettype wire
